### sv/quarter_wave_sine_dds_assert.svh
// Assertion macros for the quarter-wave sine synthesizer.
// QWD_ASSERT checks a property that is disabled while reset is high.
// QWD_ASSERT_ALWAYS checks a property at every rising clock edge, reset included.
`ifndef QUARTER_WAVE_SINE_DDS_ASSERT_SVH
`define QUARTER_WAVE_SINE_DDS_ASSERT_SVH

`ifndef SYNTHESIS

`define QWD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define QWD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QWD_ASSERT(lbl, clk, rst, prop, msg)

`define QWD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/qwdds_pkg.sv
`default_nettype none

package qwdds_pkg;

   localparam int QUARTER_SIZE_DEFAULT = 32;
   localparam int BASE_QUARTER         = 32;

   localparam int STEP_W  = 21;
   localparam int FRAC_W  = 16;
   localparam int DELTA_W = 5;    // integer step 0..16 plus one carry
   localparam int ACC_W   = 18;
   localparam int DUTY_W  = 8;
   localparam int QUAD_W  = 2;

   localparam logic [STEP_W-1:0] STEP_MAX = 21'h100000;

   localparam logic signed [ACC_W-1:0] FRAC_HALF = 18'sh08000;
   localparam logic signed [ACC_W-1:0] FRAC_ONE  = 18'sh10000;
   localparam logic signed [ACC_W-1:0] ACC_LO    = -18'sh07FFF;
   localparam logic signed [ACC_W-1:0] ACC_HI    = 18'sh08000;

   localparam logic [DUTY_W-1:0] BASE_SINE [0:BASE_QUARTER] = '{
      8'd128, 8'd135, 8'd141, 8'd147, 8'd153, 8'd159, 8'd165, 8'd171,
      8'd177, 8'd182, 8'd188, 8'd193, 8'd199, 8'd204, 8'd209, 8'd213,
      8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
      8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
      8'd255
   };

endpackage

`default_nettype wire

### sv/quarter_wave_sine_dds.sv
// Channel  Direction  Handshake             Word
// req      in         req_valid/req_stall   req_tick
// rsp      out        rsp_valid/rsp_stall   rsp_duty, rsp_quadrant
// csr      in         csr_valid/csr_ready   csr_phase_step
//
// One word per clock sustained while rsp is not stalled; a tick taken into the input register
// lands in the result register after the phase update and table read, then shows on rsp.
// Words with tick low are taken and dropped without touching the phase.
// Synchronous reset clears phase, quadrant, accumulator and duty; no clearing pass.
// A stall on rsp holds the result register and backs up into req_stall;
// csr_ready is always high.
`default_nettype none

module quarter_wave_sine_dds #(
   parameter int QUARTER_SIZE = qwdds_pkg::QUARTER_SIZE_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,

   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_tick,

   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [qwdds_pkg::DUTY_W-1:0]  rsp_duty,
   output logic [qwdds_pkg::QUAD_W-1:0]  rsp_quadrant,

   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [qwdds_pkg::STEP_W-1:0]  csr_phase_step
);

   import qwdds_pkg::*;

`include "quarter_wave_sine_dds_assert.svh"

   localparam int IW = $clog2(QUARTER_SIZE + 1);
   localparam int SW = $clog2(2 * QUARTER_SIZE + 1) + 2;

   localparam logic signed [SW-1:0] QS_S     = SW'(QUARTER_SIZE);
   localparam logic signed [SW-1:0] TWO_QS_S = SW'(2 * QUARTER_SIZE);
   localparam logic signed [SW-1:0] ZERO_S   = '0;

   // resampled quarter table, built at elaboration
   logic [DUTY_W-1:0] table_rom [0:QUARTER_SIZE];

   for (genvar i = 0; i <= QUARTER_SIZE; i++) begin : g_rom
      localparam int K  = (i * BASE_QUARTER + QUARTER_SIZE / 2) / QUARTER_SIZE;
      localparam int KC = (K > BASE_QUARTER) ? BASE_QUARTER : K;
      assign table_rom[i] = BASE_SINE[KC];
   end

   logic [STEP_W-1:0]       phase_step_ff, phase_step_in;
   logic                    in_valid_ff, in_valid_in;
   logic                    tick_ff, tick_in;
   logic [DUTY_W-1:0]       next_duty_ff, next_duty_in;
   logic [IW-1:0]           table_index_ff, table_index_in;
   logic [QUAD_W-1:0]       quadrant_ff, quadrant_in;
   logic signed [ACC_W-1:0] fraction_accum_ff, fraction_accum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]       rsp_duty_ff, rsp_duty_in;
   logic [QUAD_W-1:0]       rsp_quadrant_ff, rsp_quadrant_in;

   logic                    out_free, in_move, in_free, accept, tick_move;
   logic signed [ACC_W-1:0] acc_sum;
   logic                    carry;
   logic [DELTA_W-1:0]      delta;
   logic signed [SW-1:0]    idx_cur, delta_s, idx_step, idx_ref, idx_clamp;
   logic                    advance;
   logic [IW-1:0]           idx_new;
   logic [DUTY_W-1:0]       table_val;

   assign csr_ready = 1'b1;

   always_comb begin
      phase_step_in = phase_step_ff;
      if (csr_valid && csr_ready) begin
         phase_step_in = (csr_phase_step > STEP_MAX) ? STEP_MAX : csr_phase_step;
      end
   end

   // handshake: ticks need a free result slot, empty words just drain
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && (!tick_ff || out_free);
   assign in_free   = !in_valid_ff || in_move;
   assign req_stall = !in_free;
   assign accept    = req_valid && in_free;
   assign tick_move = in_valid_ff && tick_ff && out_free;

   assign in_valid_in = accept || (in_valid_ff && !in_move);
   assign tick_in     = accept ? req_tick : tick_ff;

   // fraction gathering
   always_comb begin
      acc_sum = fraction_accum_ff + $signed({{(ACC_W - FRAC_W){1'b0}},
                                             phase_step_ff[FRAC_W-1:0]});
      carry   = acc_sum > FRAC_HALF;
      delta   = phase_step_ff[STEP_W-1:FRAC_W] + DELTA_W'(carry);
   end

   // index step with fold at the table ends
   always_comb begin
      idx_cur = $signed({{(SW - IW){1'b0}}, table_index_ff});
      delta_s = $signed({{(SW - DELTA_W){1'b0}}, delta});
      if (!quadrant_ff[0]) begin
         idx_step = idx_cur + delta_s;
         advance  = idx_step >= QS_S;
         idx_ref  = advance ? (TWO_QS_S - idx_step) : idx_step;
      end else begin
         idx_step = idx_cur - delta_s;
         advance  = idx_step <= ZERO_S;
         idx_ref  = advance ? (ZERO_S - idx_step) : idx_step;
      end
      if (idx_ref < ZERO_S) begin
         idx_clamp = ZERO_S;
      end else if (idx_ref > QS_S) begin
         idx_clamp = QS_S;
      end else begin
         idx_clamp = idx_ref;
      end
      idx_new   = idx_clamp[IW-1:0];
      table_val = table_rom[idx_new];
   end

   always_comb begin
      next_duty_in      = next_duty_ff;
      table_index_in    = table_index_ff;
      quadrant_in       = quadrant_ff;
      fraction_accum_in = fraction_accum_ff;
      if (tick_move) begin
         next_duty_in      = quadrant_ff[1] ? (DUTY_W'(0) - table_val) : table_val;
         table_index_in    = idx_new;
         quadrant_in       = quadrant_ff + QUAD_W'(advance);
         fraction_accum_in = carry ? (acc_sum - FRAC_ONE) : acc_sum;
      end
   end

   // result word: duty from the previous tick, quadrant after this one
   assign rsp_valid_in    = tick_move || (rsp_valid_ff && rsp_stall);
   assign rsp_duty_in     = tick_move ? next_duty_ff : rsp_duty_ff;
   assign rsp_quadrant_in = tick_move ? quadrant_in : rsp_quadrant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff     <= '0;
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         next_duty_ff      <= '0;
         table_index_ff    <= '0;
         quadrant_ff       <= '0;
         fraction_accum_ff <= '0;
      end else begin
         phase_step_ff     <= phase_step_in;
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         next_duty_ff      <= next_duty_in;
         table_index_ff    <= table_index_in;
         quadrant_ff       <= quadrant_in;
         fraction_accum_ff <= fraction_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff         <= tick_in;
      rsp_duty_ff     <= rsp_duty_in;
      rsp_quadrant_ff <= rsp_quadrant_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_duty     = rsp_duty_ff;
   assign rsp_quadrant = rsp_quadrant_ff;

   `QWD_ASSERT(a_accum_range, clock, reset, (fraction_accum_ff >= ACC_LO) && (fraction_accum_ff <= ACC_HI), "fraction accumulator out of range")
   `QWD_ASSERT(a_index_range, clock, reset, (table_index_ff <= IW'(QUARTER_SIZE)), "table index past end of quarter")
   `QWD_ASSERT(a_tick_held, clock, reset, (in_valid_ff && tick_ff && !out_free) |=> (in_valid_ff && tick_ff), "blocked tick lost from input stage")
   `QWD_ASSERT(a_tick_result, clock, reset, tick_move |=> (rsp_valid_ff && (rsp_duty_ff == $past(next_duty_ff))), "tick did not load result word")

endmodule

`default_nettype wire

### tb/tb_quarter_wave_sine_dds.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_quarter_wave_sine_dds;
   import qwdds_pkg::*;

   localparam int QSIZE = qwdds_pkg::QUARTER_SIZE_DEFAULT;
   localparam int LIMIT = 200000;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE = 6;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [QUAD_W-1:0] quadrant;
   } dds_word_type;

   typedef enum logic [1:0] {ROW_TICK, ROW_SKIP, ROW_STEP} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [STEP_W-1:0] arg;
      logic              typed;
      dds_word_type      want;
   } row_type;

   localparam logic [7:0] SINE_QUARTER [0:32] = '{
      8'd128, 8'd135, 8'd141, 8'd147, 8'd153, 8'd159, 8'd165, 8'd171,
      8'd177, 8'd182, 8'd188, 8'd193, 8'd199, 8'd204, 8'd209, 8'd213,
      8'd218, 8'd222, 8'd226, 8'd230, 8'd234, 8'd237, 8'd240, 8'd243,
      8'd245, 8'd248, 8'd250, 8'd251, 8'd253, 8'd254, 8'd254, 8'd255,
      8'd255
   };

   // full-scale step walks one whole sine period in eight ticks
   localparam row_type SCRIPT [0:24] = '{
      '{ROW_TICK, 21'h0,      1'b1, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd128, 2'd0}},
      '{ROW_SKIP, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_STEP, 21'h1FFFFF, 1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd128, 2'd0}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd218, 2'd1}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd255, 2'd1}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd218, 2'd2}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd128, 2'd2}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd38,  2'd3}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd1,   2'd3}},
      '{ROW_TICK, 21'h0,      1'b1, '{8'd38,  2'd0}},
      '{ROW_STEP, 21'h100001, 1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_STEP, 21'h018000, 1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_STEP, 21'h0FFFFF, 1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_STEP, 21'h000001, 1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}},
      '{ROW_STEP, 21'h008001, 1'b0, '{8'd0,   2'd0}},
      '{ROW_TICK, 21'h0,      1'b0, '{8'd0,   2'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_tick = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DUTY_W-1:0] rsp_duty;
   logic [QUAD_W-1:0] rsp_quadrant;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [STEP_W-1:0] csr_phase_step = '0;

   // predicted phase state
   int          dds_step;
   logic [7:0]  queued_duty;
   int          lut_pos;
   logic [1:0]  dds_quad;
   int          frac_sum;

   dds_word_type sine_words_due[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int words_checked = 0;
   int tick_count = 0;
   int skip_count = 0;
   int step_writes = 0;

   quarter_wave_sine_dds #(.QUARTER_SIZE(QSIZE)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_tick       (req_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_duty       (rsp_duty),
      .rsp_quadrant   (rsp_quadrant),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_phase_step (csr_phase_step)
   );

   always #6 clock = ~clock;

   function automatic dds_word_type advance_sine();
      dds_word_type w;
      int delta;
      int nxt;
      int k;
      logic wrap;
      logic [7:0] mag;
      w.duty = queued_duty;
      delta = dds_step / 65536;
      frac_sum = frac_sum + (dds_step % 65536);
      if (frac_sum > 32768) begin
         delta = delta + 1;
         frac_sum = frac_sum - 65536;
      end
      wrap = 1'b0;
      if (!dds_quad[0]) begin
         nxt = lut_pos + delta;
         if (nxt >= QSIZE) begin
            nxt = 2 * QSIZE - nxt;
            wrap = 1'b1;
         end
      end else begin
         nxt = lut_pos - delta;
         if (nxt <= 0) begin
            nxt = -nxt;
            wrap = 1'b1;
         end
      end
      if (nxt < 0) nxt = 0;
      if (nxt > QSIZE) nxt = QSIZE;
      lut_pos = nxt;
      k = (nxt * 32 + QSIZE / 2) / QSIZE;
      if (k > 32) k = 32;
      mag = SINE_QUARTER[k];
      // lower half of the wave: negation picked by the pre-fold quadrant
      queued_duty = dds_quad[1] ? (~mag + 8'd1) : mag;
      dds_quad = dds_quad + {1'b0, wrap};
      w.quadrant = dds_quad;
      return w;
   endfunction

   // lowers valid and waits for every predicted word to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sine_words_due.size() != 0);
   endtask

   task automatic load_step(input logic [STEP_W-1:0] v);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_phase_step <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dds_step = (v > STEP_MAX) ? int'(STEP_MAX) : int'(v);
      step_writes++;
   endtask

   task automatic offer(input logic t, input logic typed, input dds_word_type want);
      dds_word_type w;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_tick <= 1'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= t;
      do @(posedge clock); while (req_stall);
      if (t) begin
         w = advance_sine();
         if (typed) w = want;
         sine_words_due.push_back(w);
         tick_count++;
      end else begin
         skip_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_seen != hold_ask) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      dds_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sine_words_due.size() == 0) begin
            $error("unexpected word: duty %0d quadrant %0d", rsp_duty, rsp_quadrant);
            mismatches++;
         end else begin
            w = sine_words_due.pop_front();
            words_checked++;
            if (rsp_duty !== w.duty) begin
               $error("duty: expected %0d, got %0d", w.duty, rsp_duty);
               mismatches++;
            end
            if (rsp_quadrant !== w.quadrant) begin
               $error("quadrant: expected %0d, got %0d", w.quadrant, rsp_quadrant);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      row_type r;
      logic [STEP_W-1:0] v;
      dds_step = 0;
      queued_duty = '0;
      lut_pos = 0;
      dds_quad = '0;
      frac_sum = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_stall_pct = 78;
      for (int i = 0; i < 25; i++) begin
         r = SCRIPT[i];
         case (r.kind)
            ROW_STEP: load_step(r.arg);
            ROW_SKIP: offer(1'b0, 1'b0, '0);
            default:  offer(1'b1, r.typed, r.want);
         endcase
      end

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 10;
               recv_stall_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_stall_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int s = 0; s < 7; s++) begin
            case ($urandom_range(0, 5))
               0: v = '0;
               1: v = STEP_MAX;
               2: v = STEP_W'($urandom_range(int'(STEP_MAX) + 1, 21'h1FFFFF));
               3: v = {STEP_W'($urandom_range(0, 16)) << 16} | 21'h08000;
               default: v = STEP_W'($urandom_range(0, int'(STEP_MAX)));
            endcase
            load_step(v);
            // long back-pressure so the pipe fills and req_stall rises
            if (p == 2 && s == 1) hold_ask++;
            for (int n = 0; n < 78; n++) begin
               while ($urandom_range(0, 7) == 0) offer(1'b0, 1'b0, '0);
               offer(1'b1, 1'b0, '0);
               if (p == 2 && s == 4 && n == 44) wait_drained();
            end
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("%0d ticks and %0d idle words sent over %0d phase-step settings",
               tick_count, skip_count, step_writes);
      $display("%0d duty/quadrant words checked, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0 && sine_words_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
